>>> hdl/trs_pkg.sv
`default_nettype none

package trs_pkg;

  localparam int POS_W       = 32;
  localparam int BYTE_W      = 8;
  localparam int FILL_W      = 7;
  localparam int COUNT_W     = 7;
  localparam int CAPACITY_DEF = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [BYTE_W-1:0] data_byte;
    logic              has_byte;
    logic              end_mark;
    logic [FILL_W-1:0] output_fill;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic               out_valid;
    logic               last;
    logic               stream_ended;
    logic [COUNT_W-1:0] unassembled_count;
    logic               is_empty;
  } out_t;

  // classified word handed from front to back
  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [BYTE_W-1:0] data_byte;
    logic              has_byte;
    logic              end_mark;
    logic [POS_W-1:0]  end_cand;
    logic [FILL_W-1:0] window;
  } cls_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_STORE,
    B_SCAN,
    B_RD,
    B_WR
  } back_state_t;

endpackage

`default_nettype wire

>>> hdl/trs_ram.sv
`default_nettype none

module trs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/trs_front.sv
`default_nettype none

module trs_front #(
  parameter int CAPACITY = trs_pkg::CAPACITY_DEF
) (
  input  wire trs_pkg::in_t in_word,
  output trs_pkg::cls_t     cls_word
);

  localparam logic [trs_pkg::FILL_W-1:0] CAP = trs_pkg::FILL_W'(CAPACITY);

  always_comb begin
    cls_word.position  = in_word.position;
    cls_word.data_byte = in_word.data_byte;
    cls_word.has_byte  = in_word.has_byte;
    cls_word.end_mark  = in_word.end_mark;
    // end after this byte; saturates at all ones
    if (in_word.has_byte && (in_word.position != '1)) begin
      cls_word.end_cand = in_word.position + trs_pkg::POS_W'(1);
    end else begin
      cls_word.end_cand = in_word.position;
    end
    if (in_word.output_fill >= CAP) begin
      cls_word.window = '0;
    end else begin
      cls_word.window = CAP - in_word.output_fill;
    end
  end

endmodule

`default_nettype wire

>>> hdl/trs_fifo.sv
`default_nettype none

module trs_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire trs_pkg::cls_t push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               not_empty,
  output trs_pkg::cls_t      pop_data
);

  localparam int DEPTH = trs_pkg::QUEUE_DEPTH;
  localparam int PW    = trs_pkg::QPTR_W;
  localparam int CW    = trs_pkg::QCNT_W;

  trs_pkg::cls_t   entry_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   fill_r;

  assign full      = (fill_r == CW'(DEPTH));
  assign not_empty = (fill_r != '0);
  assign pop_data  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + CW'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/trs_back.sv
`default_nettype none

module trs_back #(
  parameter int CAPACITY = trs_pkg::CAPACITY_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire trs_pkg::cls_t q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output trs_pkg::out_t      out_data
);

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int RUN_W  = $clog2(CAPACITY + 1);
  localparam int POS_W  = trs_pkg::POS_W;
  localparam int CNT_W  = trs_pkg::COUNT_W;
  localparam logic [SLOT_W:0]   CAP_S   = (SLOT_W + 1)'(CAPACITY);
  localparam logic [SLOT_W-1:0] LAST_SL = SLOT_W'(CAPACITY - 1);

  trs_pkg::back_state_t state_r, state_nxt;

  trs_pkg::cls_t         item_r;
  logic [POS_W-1:0]      next_pos_r;
  logic [POS_W-1:0]      end_r;
  logic [CNT_W-1:0]      count_r;
  logic [SLOT_W-1:0]     next_slot_r;
  logic [SLOT_W-1:0]     rd_slot_r;
  logic [RUN_W-1:0]      run_r;
  logic [RUN_W-1:0]      left_r;
  logic [CAPACITY-1:0]   valid_r;
  logic                  out_valid_r;
  trs_pkg::out_t         out_data_r;

  logic [POS_W-1:0]      diff;
  logic                  store_ok;
  logic [SLOT_W:0]       st_sum;
  logic [SLOT_W-1:0]     st_slot;
  logic                  st_hit;
  logic                  scan_go;
  logic                  out_free;
  logic                  is_stat;
  logic                  ram_we;
  logic                  ram_re;
  logic                  out_ld;
  logic [trs_pkg::BYTE_W-1:0] ram_rdata;

  // offset from next expected position; below window means it fits the ring
  assign diff     = item_r.position - next_pos_r;
  assign store_ok = item_r.has_byte && (item_r.position >= next_pos_r) &&
                    (item_r.position < end_r) && (diff < POS_W'(item_r.window));
  assign st_sum   = {1'b0, next_slot_r} + {1'b0, diff[SLOT_W-1:0]};
  assign st_slot  = (st_sum >= CAP_S) ? SLOT_W'(st_sum - CAP_S) : st_sum[SLOT_W-1:0];
  assign st_hit   = store_ok && !valid_r[st_slot];
  assign scan_go  = (run_r < RUN_W'(CAPACITY)) && (next_pos_r < end_r) &&
                    valid_r[next_slot_r];
  assign out_free = !out_valid_r || !out_stall;
  assign is_stat  = (left_r == '0);

  trs_ram #(
    .WIDTH (trs_pkg::BYTE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (st_slot),
    .wr_data (item_r.data_byte),
    .rd_en   (ram_re),
    .rd_addr (rd_slot_r),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= trs_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    out_ld    = 1'b0;
    unique case (state_r)
      trs_pkg::B_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = trs_pkg::B_STORE;
        end
      end
      trs_pkg::B_STORE: begin
        ram_we    = st_hit;
        state_nxt = trs_pkg::B_SCAN;
      end
      trs_pkg::B_SCAN: begin
        if (!scan_go) begin
          state_nxt = (run_r == '0) ? trs_pkg::B_WR : trs_pkg::B_RD;
        end
      end
      trs_pkg::B_RD: begin
        ram_re    = 1'b1;
        state_nxt = trs_pkg::B_WR;
      end
      trs_pkg::B_WR: begin
        if (out_free) begin
          out_ld = 1'b1;
          if (is_stat || (left_r == RUN_W'(1))) begin
            state_nxt = trs_pkg::B_IDLE;
          end else begin
            state_nxt = trs_pkg::B_RD;
          end
        end
      end
      default: state_nxt = trs_pkg::B_IDLE;
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_data;
    end
    if (state_r == trs_pkg::B_STORE) begin
      rd_slot_r <= next_slot_r;
    end else if (out_ld && !is_stat) begin
      rd_slot_r <= (rd_slot_r == LAST_SL) ? '0 : rd_slot_r + SLOT_W'(1);
    end
    if (out_ld) begin
      out_data_r.out_byte          <= is_stat ? '0 : ram_rdata;
      out_data_r.out_valid         <= !is_stat;
      out_data_r.last              <= is_stat || (left_r == RUN_W'(1));
      out_data_r.stream_ended      <= (next_pos_r == end_r);
      out_data_r.unassembled_count <= count_r;
      out_data_r.is_empty          <= (count_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_pos_r  <= '0;
      end_r       <= '1;
      count_r     <= '0;
      next_slot_r <= '0;
      run_r       <= '0;
      left_r      <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        trs_pkg::B_STORE: begin
          if (st_hit) begin
            valid_r[st_slot] <= 1'b1;
            count_r          <= count_r + CNT_W'(1);
          end
          if (item_r.end_mark && (item_r.end_cand < end_r)) begin
            end_r <= item_r.end_cand;
          end
          run_r <= '0;
        end
        trs_pkg::B_SCAN: begin
          // drained slots are freed during the scan; data stays in the RAM
          if (scan_go) begin
            valid_r[next_slot_r] <= 1'b0;
            count_r              <= count_r - CNT_W'(1);
            next_pos_r           <= next_pos_r + POS_W'(1);
            next_slot_r          <= (next_slot_r == LAST_SL) ? '0 : next_slot_r + SLOT_W'(1);
            run_r                <= run_r + RUN_W'(1);
          end else begin
            left_r <= run_r;
          end
        end
        trs_pkg::B_WR: begin
          if (out_ld && !is_stat) begin
            left_r <= left_r - RUN_W'(1);
          end
        end
        default: begin
        end
      endcase
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    32'($countones(valid_r)) == 32'(count_r))
    else $error("stored count differs from number of valid slots");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(CAPACITY))
    else $error("stored count above capacity");

  a_load_only_in_wr: assert property (@(posedge clk) disable iff (!rst_n)
    out_ld |-> (state_r == trs_pkg::B_WR))
    else $error("result loaded outside emit state");

  a_no_advance_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == trs_pkg::B_SCAN && next_pos_r == end_r) |=> $stable(next_pos_r))
    else $error("next position advanced past end");
`endif

endmodule

`default_nettype wire

>>> hdl/tcp_stream_reassembler.sv
`default_nettype none

// Byte-stream reassembler. Each input word carries one byte at its absolute
// stream position (or only an end mark) plus the downstream buffer fill; the
// block stores it in a CAPACITY-slot ring and then releases every contiguous
// byte in order, one result word per byte, or one status-only word when
// nothing is released. The last word of each input has last set, and the
// status fields on every word give the state after the whole input.
// Operation: a two-entry queue takes input words while the back end works. For
// each input the back end pops the word, stores it and updates the end
// position, runs a valid-bit scan that advances one slot per cycle, then does
// a data RAM read and an output register load per released byte (only the
// load when it releases none). Output stalls hold the back end in its load
// step until the output is free. No clearing pass is needed after reset.
module tcp_stream_reassembler #(
  parameter int CAPACITY = trs_pkg::CAPACITY_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire trs_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output trs_pkg::out_t     out_data
);

  trs_pkg::cls_t cls_word;
  trs_pkg::cls_t q_data;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;

  assign in_stall = q_full;

  trs_front #(
    .CAPACITY (CAPACITY)
  ) u_front (
    .in_word  (in_data),
    .cls_word (cls_word)
  );

  trs_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && !q_full),
    .push_data (cls_word),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  trs_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
